@@ hw/rtl/rsfs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the range sensor fusion steering block
// no dependencies; used by rsfs_div and the top level

package rsfs_pkg;

    // motor command codes
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_STOP    = 3'd1;
    localparam logic [2:0] CMD_FORWARD = 3'd2;
    localparam logic [2:0] CMD_RIGHT45 = 3'd3;
    localparam logic [2:0] CMD_LEFT45  = 3'd4;

    // request type codes
    localparam logic [1:0] REQ_LEFT = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_STOP_DISTANCE  = 3'd0;
    localparam logic [2:0] CFG_DECISION_TICKS = 3'd1;
    localparam logic [2:0] CFG_LEFT_WINDOW    = 3'd2;
    localparam logic [2:0] CFG_RIGHT_WINDOW   = 3'd3;
    localparam logic [2:0] CFG_RIGHT_SCALE    = 3'd4;

    // divider widths
    localparam int DIV_NUM_W  = 18;
    localparam int DIV_DEN_W  = 10;
    localparam int DIV_Q_W    = 14;
    localparam int DIV_STEP_W = 5;

    typedef struct packed {
        logic                  start;
        logic [DIV_DEN_W-1:0]  rem_init;
        logic [DIV_NUM_W-1:0]  bits;
        logic [DIV_STEP_W-1:0] steps;
        logic [DIV_DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ hw/rtl/range_sensor_fusion_steering.sv @@
`timescale 1ns / 1ps
// range sensor fusion steering: fuses left sonar, right duty and front adc
// into motor commands. depends on rsfs_pkg and rsfs_div.
//
// usage:
//   input channel s_*: one item per transfer; s_req_type selects a left
//   reading (three ascii digits), a tick (right level and front sample) or
//   a bare turn check. result channel m_*: exactly one result per item with
//   the command issued and the current left, front and right distances.
//   cfg_we/cfg_index/cfg_wdata write the five settings while idle.
// sequence:
//   one item at a time. a tick or a turn check without a decision passes
//   through update, check and done; a steering decision adds the multiply,
//   saturation check, 8 divider steps, the divider's done strobe and the
//   decision (no divider when the estimate saturates or the duty count is
//   zero); a valid left reading adds the sum update, 14 divider steps and
//   the done strobe. s_ready rises with m_valid.
// reset and stall:
//   aresetn (synchronous) restores the default settings and clears the
//   filters. a new item is taken while a result waits in the output
//   register; the block then holds its next result until m_ready.

module range_sensor_fusion_steering
    import rsfs_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [7:0]          s_digit_hundreds,
    input  logic [7:0]          s_digit_tens,
    input  logic [7:0]          s_digit_units,
    input  logic                s_right_level,
    input  logic [ADC_BITS-1:0] s_front_adc,
    input  logic                s_turn_done,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_motor_cmd,
    output logic [9:0]          m_left_dist,
    output logic [8:0]          m_front_dist,
    output logic [7:0]          m_right_dist,

    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [8:0]          cfg_wdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_UPD  = 4'd1;
    localparam logic [3:0] ST_LSUM = 4'd2;
    localparam logic [3:0] ST_LDIV = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_RMUL = 4'd5;
    localparam logic [3:0] ST_RSAT = 4'd6;
    localparam logic [3:0] ST_RDIV = 4'd7;
    localparam logic [3:0] ST_DEC  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    localparam logic [DIV_STEP_W-1:0] LEFT_DIV_STEPS  = DIV_STEP_W'(14);
    localparam logic [DIV_STEP_W-1:0] RIGHT_DIV_STEPS = DIV_STEP_W'(8);
    localparam logic [9:0]  LEFT_AVG_MAX = 10'd999;
    localparam logic [13:0] LEFT_SUM_MAX = 14'h3fff;

    // settings
    logic [8:0] stop_distance_reg;
    logic [6:0] decision_ticks_reg;
    logic [3:0] left_window_reg;
    logic [8:0] right_window_reg;
    logic [7:0] right_scale_reg;

    // filter state
    logic [13:0] left_sum_reg;
    logic [4:0]  left_count_reg;
    logic [9:0]  left_avg_reg;
    logic [9:0]  right_high_reg;
    logic [9:0]  right_count_reg;
    logic [8:0]  front_reg;
    logic [7:0]  right_reg;
    logic [6:0]  tick_count_reg;
    logic        turning_reg;

    // control
    logic [3:0]  state_reg;
    logic [2:0]  cmd_reg;
    logic        m_valid_reg;

    // captured item and intermediates
    logic [1:0]          in_req_reg;
    logic [7:0]          in_h_reg;
    logic [7:0]          in_t_reg;
    logic [7:0]          in_u_reg;
    logic                in_level_reg;
    logic [ADC_BITS-1:0] in_adc_reg;
    logic                in_turn_done_reg;
    logic [11:0]         sample_reg;
    logic [17:0]         prod_reg;

    // output register
    logic [2:0] out_cmd_reg;
    logic [9:0] out_left_reg;
    logic [8:0] out_front_reg;
    logic [7:0] out_right_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    rsfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // front scaling to 9 bits
    logic [8:0] front_scaled;
    generate
        if (ADC_BITS >= 9) begin : g_front_shr
            assign front_scaled = 9'(in_adc_reg >> (ADC_BITS - 9));
        end else begin : g_front_shl
            assign front_scaled = {in_adc_reg, {(9 - ADC_BITS){1'b0}}};
        end
    endgenerate

    // left sample decode and clamp
    logic        digits_ok;
    logic [9:0]  sample_raw;
    logic [11:0] avg_inc;
    logic [11:0] left_limit;
    logic [11:0] sample_next;

    always_comb begin
        digits_ok = (in_h_reg >= 8'h30) && (in_h_reg <= 8'h39)
                 && (in_t_reg >= 8'h30) && (in_t_reg <= 8'h39)
                 && (in_u_reg >= 8'h30) && (in_u_reg <= 8'h39);
        sample_raw = 10'({6'd0, in_h_reg[3:0]} * 10'd100)
                   + 10'({6'd0, in_t_reg[3:0]} * 10'd10)
                   + {6'd0, in_u_reg[3:0]};
        avg_inc    = {2'b00, left_avg_reg} + 12'd1;
        left_limit = {avg_inc[10:0], 1'b0} + avg_inc;
        sample_next = ({2'b00, sample_raw} > left_limit) ? left_limit
                                                          : {2'b00, sample_raw};
    end

    // left accumulate with window halving
    logic [14:0] sum_add;
    logic [13:0] sum_sat;
    logic [4:0]  cnt_inc;
    logic        left_halve;
    logic [13:0] left_sum_next;
    logic [4:0]  left_count_next;

    always_comb begin
        sum_add         = {1'b0, left_sum_reg} + {3'b000, sample_reg};
        sum_sat         = sum_add[14] ? LEFT_SUM_MAX : sum_add[13:0];
        cnt_inc         = left_count_reg + 5'd1;
        left_halve      = (cnt_inc > {1'b0, left_window_reg});
        left_sum_next   = left_halve ? {1'b0, sum_sat[13:1]} : sum_sat;
        left_count_next = left_halve ? {1'b0, cnt_inc[4:1]} : cnt_inc;
    end

    // right duty count with window halving
    logic [9:0] high_inc;
    logic [9:0] rcnt_inc;
    logic       right_halve;

    always_comb begin
        high_inc    = right_high_reg + {9'd0, in_level_reg};
        rcnt_inc    = right_count_reg + 10'd1;
        right_halve = (rcnt_inc > {1'b0, right_window_reg});
    end

    logic prod_sat;
    assign prod_sat = (prod_reg >= {right_count_reg, 8'd0});

    // divider requests
    always_comb begin
        div_req = '0;
        if (state_reg == ST_LSUM && left_count_next != 5'd0) begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.bits     = {left_sum_next, 4'd0};
            div_req.steps    = LEFT_DIV_STEPS;
            div_req.den      = {5'd0, left_count_next};
        end else if (state_reg == ST_RSAT && right_count_reg != 10'd0 && !prod_sat) begin
            div_req.start    = 1'b1;
            div_req.rem_init = prod_reg[17:8];
            div_req.bits     = {prod_reg[7:0], 10'd0};
            div_req.steps    = RIGHT_DIV_STEPS;
            div_req.den      = right_count_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // settings port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_distance_reg  <= 9'd12;
            decision_ticks_reg <= 7'd100;
            left_window_reg    <= 4'd12;
            right_window_reg   <= 9'd300;
            right_scale_reg    <= 8'd200;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STOP_DISTANCE:  stop_distance_reg  <= cfg_wdata;
                CFG_DECISION_TICKS: decision_ticks_reg <= cfg_wdata[6:0];
                CFG_LEFT_WINDOW:    left_window_reg    <= cfg_wdata[3:0];
                CFG_RIGHT_WINDOW:   right_window_reg   <= cfg_wdata;
                CFG_RIGHT_SCALE:    right_scale_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // captured item, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg       <= s_req_type;
            in_h_reg         <= s_digit_hundreds;
            in_t_reg         <= s_digit_tens;
            in_u_reg         <= s_digit_units;
            in_level_reg     <= s_right_level;
            in_adc_reg       <= s_front_adc;
            in_turn_done_reg <= s_turn_done;
        end
        if (state_reg == ST_UPD) begin
            sample_reg <= sample_next;
        end
        if (state_reg == ST_RMUL) begin
            prod_reg <= 18'(right_high_reg * right_scale_reg);
        end
    end

    // sequencer and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= CMD_NONE;
            m_valid_reg     <= 1'b0;
            left_sum_reg    <= '0;
            left_count_reg  <= 5'd1;
            left_avg_reg    <= '0;
            right_high_reg  <= '0;
            right_count_reg <= 10'd1;
            front_reg       <= '0;
            right_reg       <= '0;
            tick_count_reg  <= '0;
            turning_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    cmd_reg   <= (turning_reg && in_turn_done_reg) ? CMD_STOP : CMD_NONE;
                    state_reg <= ST_CHK;
                    if (in_req_reg == REQ_LEFT) begin
                        if (digits_ok) begin
                            state_reg <= ST_LSUM;
                        end
                    end else if (in_req_reg == REQ_TICK) begin
                        right_high_reg  <= right_halve ? {1'b0, high_inc[9:1]} : high_inc;
                        right_count_reg <= right_halve ? {1'b0, rcnt_inc[9:1]} : rcnt_inc;
                        front_reg       <= front_scaled;
                        tick_count_reg  <= tick_count_reg + 7'd1;
                        if (front_scaled < stop_distance_reg && !turning_reg) begin
                            cmd_reg <= CMD_STOP;
                        end
                    end
                end
                ST_LSUM: begin
                    left_sum_reg   <= left_sum_next;
                    left_count_reg <= left_count_next;
                    if (left_count_next == 5'd0) begin
                        left_avg_reg <= '0;
                        state_reg    <= ST_CHK;
                    end else begin
                        state_reg <= ST_LDIV;
                    end
                end
                ST_LDIV: begin
                    if (div_rsp.done) begin
                        left_avg_reg <= (div_rsp.quot > {4'd0, LEFT_AVG_MAX}) ? LEFT_AVG_MAX
                                                                            : div_rsp.quot[9:0];
                        state_reg    <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    state_reg <= (tick_count_reg >= decision_ticks_reg) ? ST_RMUL : ST_DONE;
                end
                ST_RMUL: begin
                    state_reg <= ST_RSAT;
                end
                ST_RSAT: begin
                    if (right_count_reg == 10'd0) begin
                        right_reg <= '0;
                        state_reg <= ST_DEC;
                    end else if (prod_sat) begin
                        right_reg <= 8'hff;
                        state_reg <= ST_DEC;
                    end else begin
                        state_reg <= ST_RDIV;
                    end
                end
                ST_RDIV: begin
                    if (div_rsp.done) begin
                        right_reg <= div_rsp.quot[7:0];
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    tick_count_reg <= '0;
                    if (turning_reg) begin
                        turning_reg <= 1'b0;
                    end else if ({1'b0, front_reg} > left_avg_reg && front_reg > {1'b0, right_reg}) begin
                        cmd_reg <= CMD_FORWARD;
                    end else if (left_avg_reg < {2'b00, right_reg}) begin
                        turning_reg <= 1'b1;
                        cmd_reg     <= CMD_RIGHT45;
                    end else begin
                        turning_reg <= 1'b1;
                        cmd_reg     <= CMD_LEFT45;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // wait for the output register to drain
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            out_cmd_reg   <= cmd_reg;
            out_left_reg  <= left_avg_reg;
            out_front_reg <= front_reg;
            out_right_reg <= right_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_motor_cmd  = out_cmd_reg;
    assign m_left_dist  = out_left_reg;
    assign m_front_dist = out_front_reg;
    assign m_right_dist = out_right_reg;

endmodule

@@ hw/rtl/rsfs_div.sv @@
`timescale 1ns / 1ps
// bit-serial restoring divider, one quotient bit per cycle
// depends on rsfs_pkg for the request and response structs

module rsfs_div
    import rsfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_NUM_W-1:0]  bits_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [DIV_Q_W-1:0]    quot_reg;

    logic [DIV_DEN_W:0]    trial;
    logic [DIV_DEN_W:0]    diff;
    logic                  ge;
    logic [DIV_DEN_W-1:0]  rem_next;

    // shift the next numerator bit into the partial remainder
    always_comb begin
        trial    = {rem_reg, bits_reg[DIV_NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= req.steps;
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == DIV_STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.rem_init;
            bits_reg <= req.bits;
            den_reg  <= req.den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[DIV_NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ verif/range_sensor_fusion_steering_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for range_sensor_fusion_steering: random and directed sensor items
// are checked against an in-bench model of the left average, right duty and steering logic.
// depends on rsfs_pkg and the range_sensor_fusion_steering rtl

module range_sensor_fusion_steering_tb;
    import rsfs_pkg::*;

    localparam int ADC_BITS = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int TAIL_CYCLES = 40;

    // request codes not named in the package
    localparam logic [1:0] REQ_CHECK = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [7:0]          hundreds;
        logic [7:0]          tens;
        logic [7:0]          units;
        logic                level;
        logic [ADC_BITS-1:0] adc;
        logic                turn_done;
        logic                drain_first;
    } sensor_item_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [9:0] left_dist;
        logic [8:0] front_dist;
        logic [7:0] right_dist;
    } steer_out_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_req_type = 2'd0;
    logic [7:0]          s_digit_hundreds = 8'd0;
    logic [7:0]          s_digit_tens = 8'd0;
    logic [7:0]          s_digit_units = 8'd0;
    logic                s_right_level = 1'b0;
    logic [ADC_BITS-1:0] s_front_adc = '0;
    logic                s_turn_done = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [2:0]          m_motor_cmd;
    logic [9:0]          m_left_dist;
    logic [8:0]          m_front_dist;
    logic [7:0]          m_right_dist;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = 3'd0;
    logic [8:0]          cfg_wdata = 9'd0;

    sensor_item_t pending_reqs[$];
    steer_out_t   predicted_results[$];
    sensor_item_t shown_req = '0;

    int sender_gap_pct = 22;
    int receiver_stall_pct = 50;
    int mismatches = 0;
    int cycle_count = 0;

    // settings as the block holds them
    int unsigned stop_dist_set = 12;
    int unsigned decision_set = 100;
    int unsigned left_win_set = 12;
    int unsigned right_win_set = 300;
    int unsigned right_scale_set = 200;

    // filter and steering state
    int unsigned left_sum = 0;
    int unsigned left_cnt = 1;
    int unsigned left_avg = 0;
    int unsigned right_high = 0;
    int unsigned right_cnt = 1;
    int unsigned front_dist = 0;
    int unsigned right_dist = 0;
    int unsigned tick_cnt = 0;
    bit          turning = 1'b0;

    range_sensor_fusion_steering #(
        .ADC_BITS(ADC_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_digit_hundreds(s_digit_hundreds),
        .s_digit_tens    (s_digit_tens),
        .s_digit_units   (s_digit_units),
        .s_right_level   (s_right_level),
        .s_front_adc     (s_front_adc),
        .s_turn_done     (s_turn_done),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_motor_cmd     (m_motor_cmd),
        .m_left_dist     (m_left_dist),
        .m_front_dist    (m_front_dist),
        .m_right_dist    (m_right_dist),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit ascii_digit(input logic [7:0] c);
        return c >= ASCII_ZERO && c <= ASCII_NINE;
    endfunction

    // advances the fusion state by one item and returns the command and distances
    function automatic steer_out_t predict_steering(input sensor_item_t it);
        steer_out_t  res;
        logic [2:0]  cmd;
        int unsigned sample;
        int unsigned cap;
        int unsigned quo;
        cmd = CMD_NONE;
        if (turning && it.turn_done)
            cmd = CMD_STOP;
        if (it.req_type == REQ_LEFT) begin
            if (ascii_digit(it.hundreds) && ascii_digit(it.tens) && ascii_digit(it.units)) begin
                sample = 100 * (it.hundreds - ASCII_ZERO) + 10 * (it.tens - ASCII_ZERO)
                         + (it.units - ASCII_ZERO);
                cap = 3 * (left_avg + 1);
                if (sample > cap)
                    sample = cap;
                left_sum = left_sum + sample;
                if (left_sum > 16383)
                    left_sum = 16383;
                left_cnt = (left_cnt + 1) % 32;
                if (left_cnt > left_win_set) begin
                    left_sum = left_sum / 2;
                    left_cnt = left_cnt / 2;
                end
                quo = (left_cnt == 0) ? 0 : left_sum / left_cnt;
                left_avg = (quo > 999) ? 999 : quo;
            end
        end else if (it.req_type == REQ_TICK) begin
            if (it.level)
                right_high = (right_high + 1) % 1024;
            right_cnt = (right_cnt + 1) % 1024;
            if (right_cnt > right_win_set) begin
                right_high = right_high / 2;
                right_cnt = right_cnt / 2;
            end
            front_dist = it.adc >> (ADC_BITS - 9);
            if (front_dist > 511)
                front_dist = 511;
            if (front_dist < stop_dist_set && !turning)
                cmd = CMD_STOP;
            tick_cnt = (tick_cnt + 1) % 128;
        end
        if (tick_cnt >= decision_set) begin
            quo = (right_cnt == 0) ? 0 : right_high * right_scale_set / right_cnt;
            right_dist = (quo > 255) ? 255 : quo;
            if (turning) begin
                // a decision during a turn only ends it
                turning = 1'b0;
            end else if (front_dist > left_avg && front_dist > right_dist) begin
                cmd = CMD_FORWARD;
            end else if (left_avg < right_dist) begin
                turning = 1'b1;
                cmd = CMD_RIGHT45;
            end else begin
                turning = 1'b1;
                cmd = CMD_LEFT45;
            end
            tick_cnt = 0;
        end
        res.cmd = cmd;
        res.left_dist = 10'(left_avg);
        res.front_dist = 9'(front_dist);
        res.right_dist = 8'(right_dist);
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic queue_item(input logic [1:0] req, input logic [7:0] h, input logic [7:0] t,
                              input logic [7:0] u, input logic lvl,
                              input logic [ADC_BITS-1:0] adc, input logic done,
                              input logic drain);
        sensor_item_t it;
        it.req_type = req;
        it.hundreds = h;
        it.tens = t;
        it.units = u;
        it.level = lvl;
        it.adc = adc;
        it.turn_done = done;
        it.drain_first = drain;
        pending_reqs.push_back(it);
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [8:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_STOP_DISTANCE:  stop_dist_set = val;
            CFG_DECISION_TICKS: decision_set = val[6:0];
            CFG_LEFT_WINDOW:    left_win_set = val[3:0];
            CFG_RIGHT_WINDOW:   right_win_set = val;
            CFG_RIGHT_SCALE:    right_scale_set = val[7:0];
            default: ;
        endcase
    endtask

    // unused upper bits of the write data carry noise
    task automatic apply_settings(input int unsigned stop, input int unsigned dec,
                                  input int unsigned lwin, input int unsigned rwin,
                                  input int unsigned scale);
        write_setting(CFG_STOP_DISTANCE, 9'(stop));
        write_setting(CFG_DECISION_TICKS, 9'(dec | ($urandom_range(3) << 7)));
        write_setting(CFG_LEFT_WINDOW, 9'(lwin | ($urandom_range(31) << 4)));
        write_setting(CFG_RIGHT_WINDOW, 9'(rwin));
        write_setting(CFG_RIGHT_SCALE, 9'(scale | ($urandom_range(1) << 8)));
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || predicted_results.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_inputs
        sensor_item_t nxt;
        logic         took;
        if (aresetn) begin
            took = s_valid && s_ready;
            if (took)
                predicted_results.push_back(predict_steering(shown_req));
            if (took || !s_valid) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_gap_pct
                    && (!pending_reqs[0].drain_first || predicted_results.size() == 0)) begin
                    nxt = pending_reqs.pop_front();
                    shown_req <= nxt;
                    s_valid <= 1'b1;
                    s_req_type <= nxt.req_type;
                    s_digit_hundreds <= nxt.hundreds;
                    s_digit_tens <= nxt.tens;
                    s_digit_units <= nxt.units;
                    s_right_level <= nxt.level;
                    s_front_adc <= nxt.adc;
                    s_turn_done <= nxt.turn_done;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        steer_out_t want;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer with nothing expected, motor_cmd %0d",
                             $time, m_motor_cmd);
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("motor_cmd", want.cmd, m_motor_cmd);
                    compare_field("left_dist", want.left_dist, m_left_dist);
                    compare_field("front_dist", want.front_dist, m_front_dist);
                    compare_field("right_dist", want.right_dist, m_right_dist);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("range_sensor_fusion_steering: mismatch");
            $finish;
        end
    end

    initial begin
        int                  ph;
        int                  n;
        int                  roll;
        int                  lvl_bias;
        logic [1:0]          req;
        logic [7:0]          dh;
        logic [7:0]          dt;
        logic [7:0]          du;
        logic [ADC_BITS-1:0] adc;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: digit edges, invalid characters, front threshold, unused request
        queue_item(REQ_LEFT, "0", "0", "0", 1'b0, '0, 1'b0, 1'b0);
        queue_item(REQ_LEFT, "9", "9", "9", 1'b0, '0, 1'b0, 1'b0);
        queue_item(REQ_LEFT, 8'h2f, "0", "0", 1'b0, '0, 1'b0, 1'b0);
        queue_item(REQ_LEFT, "0", 8'h3a, "0", 1'b0, '0, 1'b0, 1'b0);
        queue_item(REQ_LEFT, 8'hff, 8'h00, "5", 1'b0, '0, 1'b0, 1'b0);
        queue_item(REQ_LEFT, "5", "5", 8'h80, 1'b0, '0, 1'b0, 1'b0);
        queue_item(REQ_TICK, 8'hff, 8'hff, 8'hff, 1'b1, '0, 1'b0, 1'b0);
        queue_item(REQ_TICK, "1", "2", "3", 1'b0, '1, 1'b1, 1'b0);
        queue_item(REQ_TICK, "0", "0", "0", 1'b1, 12'd95, 1'b0, 1'b0);
        queue_item(REQ_TICK, "0", "0", "0", 1'b1, 12'd96, 1'b0, 1'b0);
        queue_item(REQ_CHECK, "7", "7", "7", 1'b1, '1, 1'b1, 1'b1);
        queue_item(REQ_SPARE, "9", "9", "9", 1'b1, '0, 1'b1, 1'b0);
        // enough full-scale readings to cross the left window
        for (n = 0; n < 12; n++)
            queue_item(REQ_LEFT, "9", "9", "9", 1'b0, '0, 1'b0, 1'b0);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                sender_gap_pct = 22;
                receiver_stall_pct = 50;
            end else if (ph < 6) begin
                sender_gap_pct = 50;
                receiver_stall_pct = 22;
            end else begin
                sender_gap_pct = 0;
                receiver_stall_pct = 0;
            end
            case (ph)
                0: apply_settings(511, 127, 15, 511, 255);
                // lowered period fires at once on the ticks already counted
                1: apply_settings(0, 1, 1, 2, 1);
                2: apply_settings(0, 0, 0, 0, 0);
                default: apply_settings($urandom_range(511), $urandom_range(1, 24),
                                        $urandom_range(1, 15), $urandom_range(2, 511),
                                        $urandom_range(1, 255));
            endcase
            lvl_bias = $urandom_range(100);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 40)
                    req = REQ_LEFT;
                else if (roll < 85)
                    req = REQ_TICK;
                else if (roll < 95)
                    req = REQ_CHECK;
                else
                    req = REQ_SPARE;
                if ($urandom_range(99) < 85) begin
                    dh = 8'(ASCII_ZERO + $urandom_range(9));
                    dt = 8'(ASCII_ZERO + $urandom_range(9));
                    du = 8'(ASCII_ZERO + $urandom_range(9));
                end else begin
                    dh = 8'($urandom_range(255));
                    dt = 8'($urandom_range(255));
                    du = 8'($urandom_range(255));
                end
                // low samples keep the stop threshold busy
                if ($urandom_range(3) == 0)
                    adc = ADC_BITS'($urandom_range(255));
                else
                    adc = ADC_BITS'($urandom_range(4095));
                queue_item(req, dh, dt, du, $urandom_range(99) < lvl_bias, adc,
                           $urandom_range(99) < 40, n == ITEMS_PER_PHASE / 2);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("range_sensor_fusion_steering: match");
        else
            $display("range_sensor_fusion_steering: mismatch");
        $finish;
    end

endmodule

@@ range_sensor_fusion_steering.f @@
hw/rtl/rsfs_pkg.sv
hw/rtl/rsfs_div.sv
hw/rtl/range_sensor_fusion_steering.sv
verif/range_sensor_fusion_steering_tb.sv
